// File: rtl/priority_round_robin_thread_scheduler_core_defines.svh
// Assertion macros shared by the scheduler RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PRRTS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PRRTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRRTS_ASSERT(lbl, clk, rstn, prop, msg)
`define PRRTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/prrts_pkg.sv
// Package for the thread scheduler: command and result structs, codes, cell types.
// Used by prrts_cell and priority_round_robin_thread_scheduler_core; no dependencies.
`timescale 1ns / 1ps

package prrts_pkg;

	localparam int SLOTS_DEFAULT = 4;

	typedef enum logic [2:0] {
		K_CREATE   = 3'd0,
		K_YIELD    = 3'd1,
		K_EXIT     = 3'd2,
		K_SET_PRIO = 3'd3,
		K_GET_PRIO = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_FREE     = 2'd0,
		ST_RUNNABLE = 2'd1,
		ST_RUNNING  = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_SCAN  = 2'd1,
		S_APPLY = 2'd2
	} fsm_state_t;

	localparam logic [1:0] PRIO_HIGH = 2'd2;
	localparam logic [1:0] PRIO_SAT  = 2'd3;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] prio_in;
	} cmd_t;

	typedef struct packed {
		logic       status;
		logic [1:0] current_slot;
		logic       switched;
		logic       all_done;
		logic [1:0] prio_out;
	} result_t;

	typedef struct packed {
		slot_state_t st;
		logic [1:0]  pr;
	} cell_data_t;

	typedef struct packed {
		logic        a_hit;
		slot_state_t a_val;
		logic        b_hit;
		slot_state_t b_val;
		logic        pr_hit;
		logic [1:0]  pr_val;
	} cell_upd_t;

	function automatic logic [1:0] clamp_prio(input logic [1:0] p);
		clamp_prio = (p == PRIO_SAT) ? PRIO_HIGH : p;
	endfunction

endpackage

// File: rtl/prrts_cell.sv
// One thread slot of the scheduler ring: slot state and priority.
// Depends on prrts_pkg for the cell data and update structs.
`timescale 1ns / 1ps

module prrts_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  prrts_pkg::cell_data_t  shift_in,
	input  prrts_pkg::cell_upd_t   upd,
	output prrts_pkg::cell_data_t  q
);

	prrts_pkg::cell_data_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q.st <= prrts_pkg::ST_FREE;
			data_q.pr <= 2'd0;
		end else if (shift) begin
			data_q <= shift_in;
		end else begin
			if (upd.b_hit) begin
				data_q.st <= upd.b_val;
			end else if (upd.a_hit) begin
				data_q.st <= upd.a_val;
			end
			if (upd.pr_hit) begin
				data_q.pr <= upd.pr_val;
			end
		end
	end

	assign q = data_q;

endmodule

// File: rtl/priority_round_robin_thread_scheduler_core.sv
// Thread scheduler top level: ring of slot cells, scan unit and control FSM.
// Depends on prrts_pkg, prrts_cell and the assertion macro header.
//
// Usage: drive cmd and raise start; the command transfers at a rising edge where
// start is high and busy is low. busy stays high while the command is worked on.
// Each command yields one result, shown on result for exactly one cycle while
// done is high; the receiver cannot stall and must take it in that cycle.
// Operation: the slot ring rotates once past the scan unit, one slot per cycle,
// then the apply state writes the updates and the result; done is registered
// from the apply state. A new command may transfer in the cycle where done is
// high, but not while an earlier command is still being worked on.
// Reset: arst_n low clears all slots to free with priority zero, the current
// slot to zero and the controller to idle; no clearing pass is needed.
`timescale 1ns / 1ps
`include "priority_round_robin_thread_scheduler_core_defines.svh"

module priority_round_robin_thread_scheduler_core #(
	parameter int SLOTS = prrts_pkg::SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  prrts_pkg::cmd_t    cmd,
	output logic               done,
	output prrts_pkg::result_t result
);

	localparam int IW = $clog2(SLOTS);

	prrts_pkg::fsm_state_t state_q, state_d;

	prrts_pkg::cell_data_t cell_q [SLOTS];
	prrts_pkg::cell_upd_t  upd [SLOTS];
	prrts_pkg::cell_data_t head;

	logic [IW-1:0] step_q;
	logic [IW-1:0] cur_q, cur_d;
	logic [2:0]    kind_q;
	logic [1:0]    prio_q;
	logic          best_found_q, free_found_q;
	logic [1:0]    best_prio_q;
	logic          best_hi_q;
	logic [IW-1:0] best_idx_q, free_idx_q;
	logic [1:0]    cur_prio_q;
	prrts_pkg::slot_state_t cur_st_q;
	prrts_pkg::result_t result_q, res_d;
	logic          done_q;

	logic          accept, shift, apply;
	logic          runnable, hi, take, free_hit, cur_hit;
	logic          a_en, b_en, pr_en;
	logic [IW-1:0] a_idx, b_idx, pr_idx;
	prrts_pkg::slot_state_t a_val, b_val;
	logic [IW+1:0] cur_ext;

	genvar k;
	generate
		for (k = 0; k < SLOTS; k++) begin : g_ring
			prrts_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.shift_in (cell_q[(k + 1) % SLOTS]),
				.upd      (upd[k]),
				.q        (cell_q[k])
			);
			assign upd[k].a_hit  = a_en && (a_idx == IW'(k));
			assign upd[k].a_val  = a_val;
			assign upd[k].b_hit  = b_en && (b_idx == IW'(k));
			assign upd[k].b_val  = b_val;
			assign upd[k].pr_hit = pr_en && (pr_idx == IW'(k));
			assign upd[k].pr_val = prio_q;
		end
	endgenerate

	assign head   = cell_q[0];
	assign busy   = (state_q != prrts_pkg::S_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prrts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		shift    = 1'b0;
		apply    = 1'b0;
		runnable = (head.st == prrts_pkg::ST_RUNNABLE) &&
			!((kind_q == prrts_pkg::K_EXIT) && (step_q == cur_q));
		hi       = (step_q > cur_q);
		take     = 1'b0;
		free_hit = 1'b0;
		cur_hit  = 1'b0;
		cur_d    = cur_q;
		a_en     = 1'b0;
		a_idx    = cur_q;
		a_val    = prrts_pkg::ST_RUNNABLE;
		b_en     = 1'b0;
		b_idx    = best_idx_q;
		b_val    = prrts_pkg::ST_RUNNING;
		pr_en    = 1'b0;
		pr_idx   = cur_q;
		res_d    = '0;
		case (state_q)
			prrts_pkg::S_IDLE: begin
				if (start) begin
					state_d = prrts_pkg::S_SCAN;
				end
			end
			prrts_pkg::S_SCAN: begin
				shift    = 1'b1;
				take     = runnable && (!best_found_q || (head.pr > best_prio_q) ||
					((head.pr == best_prio_q) && hi && !best_hi_q));
				free_hit = !free_found_q && (head.st == prrts_pkg::ST_FREE);
				cur_hit  = (step_q == cur_q);
				if (step_q == IW'(SLOTS - 1)) begin
					state_d = prrts_pkg::S_APPLY;
				end
			end
			prrts_pkg::S_APPLY: begin
				apply   = 1'b1;
				state_d = prrts_pkg::S_IDLE;
				case (kind_q)
					prrts_pkg::K_CREATE: begin
						if (free_found_q) begin
							cur_d  = free_idx_q;
							a_en   = 1'b1;
							a_idx  = free_idx_q;
							pr_en  = 1'b1;
							pr_idx = free_idx_q;
						end else begin
							res_d.status = 1'b1;
						end
					end
					prrts_pkg::K_YIELD: begin
						if (best_found_q) begin
							a_en           = (cur_st_q == prrts_pkg::ST_RUNNING);
							b_en           = 1'b1;
							cur_d          = best_idx_q;
							res_d.switched = (best_idx_q != cur_q);
						end
					end
					prrts_pkg::K_EXIT: begin
						a_en  = 1'b1;
						a_val = prrts_pkg::ST_FREE;
						if (best_found_q) begin
							b_en           = 1'b1;
							cur_d          = best_idx_q;
							res_d.switched = (best_idx_q != cur_q);
						end else begin
							res_d.all_done = 1'b1;
						end
					end
					prrts_pkg::K_SET_PRIO: begin
						pr_en          = 1'b1;
						res_d.prio_out = cur_prio_q;
					end
					prrts_pkg::K_GET_PRIO: begin
						res_d.prio_out = cur_prio_q;
					end
					default: begin
					end
				endcase
				cur_ext            = {2'b00, cur_d};
				res_d.current_slot = cur_ext[1:0];
			end
			default: begin
				state_d = prrts_pkg::S_IDLE;
			end
		endcase
		cur_ext = {2'b00, cur_d};
		res_d.current_slot = cur_ext[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
			cur_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= apply;
			if (accept) begin
				step_q       <= '0;
				best_found_q <= 1'b0;
				free_found_q <= 1'b0;
			end else if (shift) begin
				step_q <= step_q + 1'b1;
				if (take) begin
					best_found_q <= 1'b1;
				end
				if (free_hit) begin
					free_found_q <= 1'b1;
				end
			end
			if (apply) begin
				cur_q <= cur_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cmd.kind;
			prio_q <= prrts_pkg::clamp_prio(cmd.prio_in);
		end
		if (take) begin
			best_prio_q <= head.pr;
			best_hi_q   <= hi;
			best_idx_q  <= step_q;
		end
		if (free_hit) begin
			free_idx_q <= step_q;
		end
		if (cur_hit) begin
			cur_prio_q <= head.pr;
			cur_st_q   <= head.st;
		end
		if (apply) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`PRRTS_ASSERT(a_done_idle, clk, arst_n, done_q |-> !busy, "result strobe while busy")
	`PRRTS_ASSERT(a_accept_busy, clk, arst_n, accept |=> busy, "transfer did not start work")
	`PRRTS_ASSERT(a_done_after_apply, clk, arst_n,
		done_q |-> $past(state_q == prrts_pkg::S_APPLY), "strobe without apply")
	`PRRTS_ASSERT(a_full_quiet, clk, arst_n,
		(done_q && result_q.status) |-> (!result_q.switched && !result_q.all_done),
		"error result with switch flags")
	`PRRTS_ASSERT(a_scan_len, clk, arst_n,
		(state_q == prrts_pkg::S_APPLY) |-> (step_q == '0 || SLOTS != (1 << IW)),
		"ring not back in place at apply")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for priority_round_robin_thread_scheduler_core: a directed
// table of commands, then random commands, each result checked against an in-bench predictor
// (pinned table rows against their fixed result). Depends on prrts_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int SLOT_COUNT = prrts_pkg::SLOTS_DEFAULT;
	localparam int RANDOM_ITEMS = 1375;
	localparam int WATCHDOG_LIMIT = 500;

	localparam logic [2:0] KIND_RSVD5 = 3'd5;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;
	localparam logic [1:0] PRIO_LOW = 2'd0;
	localparam logic [1:0] PRIO_MED = 2'd1;

	typedef struct {
		prrts_pkg::cmd_t    c;
		bit                 pinned;
		prrts_pkg::result_t want;
	} step_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	prrts_pkg::cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	prrts_pkg::result_t result;

	logic    cmd_pinned = 1'b0;
	prrts_pkg::result_t pinned_result = '0;

	prrts_pkg::slot_state_t slot_mark [SLOT_COUNT];
	logic [1:0]  slot_prio [SLOT_COUNT];
	int          cur_slot;

	prrts_pkg::result_t sched_expect [$];
	step_row_t directed_rows [$];
	prrts_pkg::result_t next_want;
	int        n_errors = 0;
	int        n_results = 0;
	int        idle_cycles = 0;

	priority_round_robin_thread_scheduler_core #(
		.SLOTS(SLOT_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [1:0] sat_prio(input logic [1:0] p);
		return (p > prrts_pkg::PRIO_HIGH) ? prrts_pkg::PRIO_HIGH : p;
	endfunction

	// Highest priority runnable slot, scanning from the slot after the current one.
	function automatic int pick_runnable();
		int best;
		int best_prio;
		int idx;
		int n;
		best = SLOT_COUNT;
		best_prio = -1;
		idx = (cur_slot + 1) % SLOT_COUNT;
		for (n = 0; n < SLOT_COUNT; n++) begin
			if (slot_mark[idx] == prrts_pkg::ST_RUNNABLE &&
					int'(slot_prio[idx]) > best_prio) begin
				best = idx;
				best_prio = int'(slot_prio[idx]);
			end
			idx = (idx + 1) % SLOT_COUNT;
		end
		return best;
	endfunction

	function automatic prrts_pkg::result_t schedule_step(input prrts_pkg::cmd_t c);
		prrts_pkg::result_t r;
		int idx;
		int nxt;
		int prev;
		r = '0;
		prev = cur_slot;
		case (c.kind)
			prrts_pkg::K_CREATE: begin
				idx = SLOT_COUNT;
				for (int i = SLOT_COUNT - 1; i >= 0; i--)
					if (slot_mark[i] == prrts_pkg::ST_FREE)
						idx = i;
				if (idx == SLOT_COUNT) begin
					r.status = 1'b1;
				end else begin
					cur_slot = idx;
					slot_prio[idx] = sat_prio(c.prio_in);
					slot_mark[idx] = prrts_pkg::ST_RUNNABLE;
				end
			end
			prrts_pkg::K_YIELD: begin
				nxt = pick_runnable();
				if (nxt < SLOT_COUNT) begin
					if (slot_mark[prev] == prrts_pkg::ST_RUNNING)
						slot_mark[prev] = prrts_pkg::ST_RUNNABLE;
					slot_mark[nxt] = prrts_pkg::ST_RUNNING;
					r.switched = (nxt != prev);
					cur_slot = nxt;
				end
			end
			prrts_pkg::K_EXIT: begin
				slot_mark[prev] = prrts_pkg::ST_FREE;
				nxt = pick_runnable();
				if (nxt < SLOT_COUNT) begin
					slot_mark[nxt] = prrts_pkg::ST_RUNNING;
					r.switched = (nxt != prev);
					cur_slot = nxt;
				end else begin
					r.all_done = 1'b1;
				end
			end
			prrts_pkg::K_SET_PRIO: begin
				r.prio_out = slot_prio[prev];
				slot_prio[prev] = sat_prio(c.prio_in);
			end
			prrts_pkg::K_GET_PRIO: begin
				r.prio_out = slot_prio[prev];
			end
			default: begin
			end
		endcase
		r.current_slot = cur_slot[1:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch at result %0d, %s: got %0d, expected %0d",
			n_results, what, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (sched_expect.size() == 0) begin
					flag_mismatch("result with nothing pending", int'(result), 0);
				end else begin
					next_want = sched_expect.pop_front();
					if (result.status !== next_want.status)
						flag_mismatch("status", int'(result.status),
							int'(next_want.status));
					if (result.current_slot !== next_want.current_slot)
						flag_mismatch("current_slot", int'(result.current_slot),
							int'(next_want.current_slot));
					if (result.switched !== next_want.switched)
						flag_mismatch("switched", int'(result.switched),
							int'(next_want.switched));
					if (result.all_done !== next_want.all_done)
						flag_mismatch("all_done", int'(result.all_done),
							int'(next_want.all_done));
					if (result.prio_out !== next_want.prio_out)
						flag_mismatch("prio_out", int'(result.prio_out),
							int'(next_want.prio_out));
				end
				n_results++;
			end
			if (start && !busy) begin
				next_want = schedule_step(cmd);
				sched_expect.push_back(cmd_pinned ? pinned_result : next_want);
			end
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic issue(input prrts_pkg::cmd_t c, input bit pinned,
			input prrts_pkg::result_t want, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			do @(posedge clk); while (busy);
			repeat (gap - 1) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		cmd_pinned <= pinned;
		pinned_result <= want;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sched_expect.size() != 0);
	endtask

	task automatic add_row(input logic [2:0] k, input logic [1:0] p, input bit pinned,
			input prrts_pkg::result_t want);
		step_row_t row;
		row.c.kind = k;
		row.c.prio_in = p;
		row.pinned = pinned;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	function automatic prrts_pkg::cmd_t random_cmd();
		prrts_pkg::cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 26)
			c.kind = prrts_pkg::K_CREATE;
		else if (pick < 52)
			c.kind = prrts_pkg::K_YIELD;
		else if (pick < 72)
			c.kind = prrts_pkg::K_EXIT;
		else if (pick < 84)
			c.kind = prrts_pkg::K_SET_PRIO;
		else if (pick < 93)
			c.kind = prrts_pkg::K_GET_PRIO;
		else
			c.kind = 3'($urandom_range(int'(KIND_RSVD5), int'(KIND_RSVD7)));
		c.prio_in = 2'($urandom_range(0, 3));
		return c;
	endfunction

	initial begin
		int idle_mode;
		int gap;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_mark[i] = prrts_pkg::ST_FREE;
			slot_prio[i] = PRIO_LOW;
		end
		cur_slot = 0;

		add_row(prrts_pkg::K_GET_PRIO, PRIO_LOW, 1'b1, '{1'b0, 2'd0, 1'b0, 1'b0, 2'd0});
		add_row(prrts_pkg::K_YIELD, PRIO_LOW, 1'b1, '{1'b0, 2'd0, 1'b0, 1'b0, 2'd0});
		add_row(prrts_pkg::K_EXIT, PRIO_LOW, 1'b1, '{1'b0, 2'd0, 1'b0, 1'b1, 2'd0});
		add_row(prrts_pkg::K_CREATE, prrts_pkg::PRIO_SAT, 1'b1,
			'{1'b0, 2'd0, 1'b0, 1'b0, 2'd0});
		add_row(prrts_pkg::K_GET_PRIO, PRIO_LOW, 1'b1, '{1'b0, 2'd0, 1'b0, 1'b0, 2'd2});
		add_row(prrts_pkg::K_CREATE, PRIO_LOW, 1'b0, '0);
		add_row(prrts_pkg::K_CREATE, PRIO_MED, 1'b0, '0);
		add_row(prrts_pkg::K_CREATE, prrts_pkg::PRIO_HIGH, 1'b0, '0);
		add_row(prrts_pkg::K_CREATE, PRIO_MED, 1'b1, '{1'b1, 2'd3, 1'b0, 1'b0, 2'd0});
		add_row(prrts_pkg::K_SET_PRIO, prrts_pkg::PRIO_SAT, 1'b0, '0);
		add_row(prrts_pkg::K_YIELD, PRIO_LOW, 1'b0, '0);
		add_row(prrts_pkg::K_YIELD, PRIO_LOW, 1'b0, '0);
		add_row(prrts_pkg::K_SET_PRIO, PRIO_LOW, 1'b0, '0);
		add_row(prrts_pkg::K_YIELD, prrts_pkg::PRIO_HIGH, 1'b0, '0);
		add_row(KIND_RSVD5, prrts_pkg::PRIO_SAT, 1'b0, '0);
		add_row(KIND_RSVD6, PRIO_MED, 1'b0, '0);
		add_row(KIND_RSVD7, prrts_pkg::PRIO_HIGH, 1'b0, '0);
		add_row(prrts_pkg::K_EXIT, PRIO_LOW, 1'b0, '0);
		add_row(prrts_pkg::K_EXIT, PRIO_LOW, 1'b0, '0);
		add_row(prrts_pkg::K_EXIT, PRIO_LOW, 1'b0, '0);
		add_row(prrts_pkg::K_EXIT, PRIO_LOW, 1'b1, '{1'b0, 2'd1, 1'b0, 1'b1, 2'd0});
		add_row(prrts_pkg::K_EXIT, PRIO_LOW, 1'b1, '{1'b0, 2'd1, 1'b0, 1'b1, 2'd0});
		add_row(prrts_pkg::K_SET_PRIO, PRIO_MED, 1'b0, '0);
		add_row(prrts_pkg::K_CREATE, prrts_pkg::PRIO_HIGH, 1'b0, '0);
		add_row(prrts_pkg::K_YIELD, PRIO_LOW, 1'b0, '0);
		add_row(prrts_pkg::K_GET_PRIO, PRIO_LOW, 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].c, directed_rows[i].pinned, directed_rows[i].want,
				(i % 3 == 1) ? int'($urandom_range(1, 13)) : 0);
		drain();

		idle_mode = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				idle_mode = $urandom_range(0, 2);
			if (n == RANDOM_ITEMS / 2)
				drain();
			gap = 0;
			if (n < RANDOM_ITEMS - 200 && idle_mode != 0)
				if ($urandom_range(0, (idle_mode == 1) ? 7 : 2) == 0)
					gap = $urandom_range(1, 13);
			issue(random_cmd(), 1'b0, '0, gap);
		end

		drain();
		repeat (SLOT_COUNT + 6) @(posedge clk);
		if (sched_expect.size() != 0)
			flag_mismatch("results never delivered", sched_expect.size(), 0);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
